// ===== rtl/ookpcr_pkg.sv =====
package ookpcr_pkg;

    localparam int MAX_TRANSITIONS_DEF = 512;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int MAX_PULSE_W = 20;
    localparam int MIN_TRANS_W = 10;
    localparam int TIMEOUT_W   = 24;
    localparam int REPEAT_W    = 8;
    localparam int GAP_W       = 16;

    localparam int TC_W    = 10;
    localparam int SINCE_W = 25;
    localparam int DUR_W   = 16;

    localparam logic [DUR_W-1:0] REPLAY_CLAMP = 16'd50000;

    localparam logic [MAX_PULSE_W-1:0] MAX_PULSE_RST = 20'd50000;
    localparam logic [MIN_TRANS_W-1:0] MIN_TRANS_RST = 10'd10;
    localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RST   = 24'd100000;
    localparam logic [REPEAT_W-1:0]    REPEAT_RST    = 8'd3;
    localparam logic [GAP_W-1:0]       GAP_RST       = 16'd10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_PULSE = 3'd0,
        REG_MIN_TRANS = 3'd1,
        REG_TIMEOUT   = 3'd2,
        REG_REPEAT    = 3'd3,
        REG_GAP       = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_PLAY  = 2'd3
    } cmd_t;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_CAPT = 2'd1;
    localparam logic [1:0] MODE_DONE = 2'd2;
    localparam logic [1:0] MODE_PLAY = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CAPT = 4'b0010,
        ST_DONE = 4'b0100,
        ST_PLAY = 4'b1000
    } state_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       rx_level;
    } in_item_t;

    typedef struct packed {
        logic            tx_level;
        logic [1:0]      mode;
        logic [TC_W-1:0] transition_count;
        logic            signal_valid;
        logic            lead_level;
    } out_item_t;

endpackage

// ===== rtl/ook_pulse_capture_replay_top.sv =====
// Channel   Dir  Handshake          Payload
// in        in   in_valid/in_stall  in_data   (cmd, rx_level), one beat per microsecond tick
// out       out  out_valid/out_stall out_data (tx_level, mode, count, valid, start level)
// cfg       in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One beat per clock while in_stall is low. Each input beat produces one
// result beat, computed in the accepting cycle and held in an output register
// backed by a one-entry skid register; in_stall is the skid register being occupied.
// Durations live in a single-port-write, registered-read memory. The read
// port always fetches the entry after the current replay index, so the next
// duration is ready when a segment ends; the first duration is kept in a flop.
// Reset is asynchronous; the duration memory is not cleared (entries are
// only read below the stored count).
module ook_pulse_capture_replay_top
    import ookpcr_pkg::*;
#(
    parameter int MAX_TRANSITIONS = MAX_TRANSITIONS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(MAX_TRANSITIONS);
    localparam int CNT_W  = $clog2(MAX_TRANSITIONS + 1);
    localparam int CMP_W  = (CNT_W > MIN_TRANS_W) ? CNT_W : MIN_TRANS_W;

    // configuration
    logic [MAX_PULSE_W-1:0] max_pulse_reg;
    logic [MIN_TRANS_W-1:0] min_trans_reg;
    logic [TIMEOUT_W-1:0]   timeout_reg;
    logic [REPEAT_W-1:0]    repeat_reg;
    logic [GAP_W-1:0]       gap_cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pulse_reg <= MAX_PULSE_RST;
            min_trans_reg <= MIN_TRANS_RST;
            timeout_reg   <= TIMEOUT_RST;
            repeat_reg    <= REPEAT_RST;
            gap_cfg_reg   <= GAP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAX_PULSE: max_pulse_reg <= cfg_data[MAX_PULSE_W-1:0];
                REG_MIN_TRANS: min_trans_reg <= cfg_data[MIN_TRANS_W-1:0];
                REG_TIMEOUT:   timeout_reg   <= cfg_data[TIMEOUT_W-1:0];
                REG_REPEAT:    repeat_reg    <= cfg_data[REPEAT_W-1:0];
                REG_GAP:       gap_cfg_reg   <= cfg_data[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // block state
    state_t               state_reg, state_next;
    logic                 first_reg, first_next;
    logic                 prev_rx_reg, prev_rx_next;
    logic [SINCE_W-1:0]   since_reg, since_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 valid_reg, valid_next;
    logic                 sl_reg, sl_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [DUR_W-1:0]     rem_reg, rem_next;
    logic [REPEAT_W-1:0]  pass_reg, pass_next;
    logic [GAP_W-1:0]     gap_reg, gap_next;
    logic                 tx_reg, tx_next;
    logic [DUR_W-1:0]     seg0_reg, seg0_next;

    // duration memory
    logic [DUR_W-1:0]     dur_mem [MAX_TRANSITIONS];
    logic [DUR_W-1:0]     rd_data_reg;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [DUR_W-1:0]     wr_data;
    logic [CNT_W-1:0]     rd_idx;

    // handshake
    logic                 accept;
    logic                 out_take;
    out_item_t            result;
    out_item_t            out_data_reg, out_data_next;
    out_item_t            skid_data_reg, skid_data_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;

    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // datapath helpers
    logic [SINCE_W-1:0]   elapsed;
    logic [DUR_W-1:0]     elapsed_clamp;
    logic                 rx_edge;
    logic                 meets_min;
    logic                 count_full;
    logic [CNT_W-1:0]     idx_inc;
    logic [REPEAT_W-1:0]  pass_inc;
    logic                 end_cap;
    logic                 pass_end;

    assign elapsed       = (since_reg == '1) ? since_reg : since_reg + 1'b1;
    assign elapsed_clamp = (elapsed > SINCE_W'(REPLAY_CLAMP)) ? REPLAY_CLAMP
                                                              : elapsed[DUR_W-1:0];
    assign rx_edge       = in_data.rx_level != prev_rx_reg;
    assign meets_min     = CMP_W'(count_reg) >= CMP_W'(min_trans_reg);
    assign count_full    = count_reg >= CNT_W'(MAX_TRANSITIONS);
    assign idx_inc       = idx_reg + 1'b1;
    assign pass_inc      = pass_reg + 1'b1;
    assign wr_data       = elapsed_clamp;

    always_comb
    begin
        state_next   = state_reg;
        first_next   = first_reg;
        prev_rx_next = prev_rx_reg;
        since_next   = since_reg;
        count_next   = count_reg;
        valid_next   = valid_reg;
        sl_next      = sl_reg;
        idx_next     = idx_reg;
        rem_next     = rem_reg;
        pass_next    = pass_reg;
        gap_next     = gap_reg;
        tx_next      = tx_reg;
        seg0_next    = seg0_reg;
        wr_en        = 1'b0;
        end_cap      = 1'b0;
        pass_end     = 1'b0;

        if (accept)
        begin
            prev_rx_next = in_data.rx_level;
            if (in_data.cmd == CMD_START)
            begin
                count_next = '0;
                valid_next = 1'b0;
                sl_next    = 1'b0;
                state_next = ST_CAPT;
                first_next = 1'b1;
                since_next = '0;
                tx_next    = 1'b0;
                idx_next   = '0;
                rem_next   = '0;
                pass_next  = '0;
                gap_next   = '0;
            end
            else
            begin
                unique case (state_reg) inside
                    ST_CAPT:
                    begin
                        if (in_data.cmd == CMD_STOP)
                            end_cap = 1'b1;
                        else if (rx_edge)
                        begin
                            if (count_full)
                                end_cap = 1'b1;
                            else
                            begin
                                if (first_reg)
                                begin
                                    first_next = 1'b0;
                                    sl_next    = in_data.rx_level;
                                end
                                else if (elapsed <= SINCE_W'(max_pulse_reg))
                                begin
                                    wr_en      = 1'b1;
                                    count_next = count_reg + 1'b1;
                                    if (count_reg == '0)
                                        seg0_next = elapsed_clamp;
                                end
                                since_next = '0;
                            end
                        end
                        else
                        begin
                            since_next = elapsed;
                            if (!first_reg && elapsed > SINCE_W'(timeout_reg))
                                end_cap = 1'b1;
                        end
                    end
                    ST_PLAY:
                    begin
                        if (idx_reg < count_reg)
                        begin
                            if (rem_reg != '0)
                                rem_next = rem_reg - 1'b1;
                            else
                            begin
                                tx_next  = ~tx_reg;
                                idx_next = idx_inc;
                                if (idx_inc < count_reg)
                                    rem_next = rd_data_reg - 1'b1;   // prefetched entry
                                else
                                begin
                                    tx_next = 1'b0;
                                    if (gap_cfg_reg != '0)
                                        gap_next = gap_cfg_reg - 1'b1;
                                    else
                                    begin
                                        gap_next = '0;
                                        pass_end = 1'b1;
                                    end
                                end
                            end
                        end
                        else
                        begin
                            tx_next = 1'b0;
                            if (gap_reg != '0)
                                gap_next = gap_reg - 1'b1;
                            else
                                pass_end = 1'b1;
                        end
                    end
                    ST_IDLE, ST_DONE:
                    begin
                        if (in_data.cmd == CMD_PLAY && valid_reg && count_reg != '0
                            && repeat_reg != '0)
                        begin
                            state_next = ST_PLAY;
                            pass_next  = '0;
                            gap_next   = '0;
                            idx_next   = '0;
                            tx_next    = ~sl_reg;
                            rem_next   = seg0_reg - 1'b1;
                        end
                    end
                    default: ;
                endcase
            end

            if (end_cap)
            begin
                state_next = meets_min ? ST_DONE : ST_IDLE;
                valid_next = meets_min;
            end

            if (pass_end)
            begin
                pass_next = pass_inc;
                if (pass_inc >= repeat_reg)
                begin
                    state_next = ST_DONE;
                    tx_next    = 1'b0;
                end
                else
                begin
                    idx_next = '0;
                    tx_next  = ~sl_reg;
                    rem_next = seg0_reg - 1'b1;
                end
            end

            if (state_next != ST_PLAY)
                tx_next = 1'b0;
        end
    end

    // always fetch the entry after the (next) replay index
    assign rd_idx  = idx_next + 1'b1;
    assign rd_addr = rd_idx[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            dur_mem[count_reg[ADDR_W-1:0]] <= wr_data;
        rd_data_reg <= dur_mem[rd_addr];
    end

    always_comb
    begin
        result.tx_level         = tx_next;
        result.transition_count = TC_W'(count_next);
        result.signal_valid     = valid_next;
        result.lead_level       = sl_next;
        unique case (state_next)
            ST_IDLE: result.mode = MODE_IDLE;
            ST_CAPT: result.mode = MODE_CAPT;
            ST_DONE: result.mode = MODE_DONE;
            ST_PLAY: result.mode = MODE_PLAY;
            default: result.mode = MODE_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_data_next  = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = result;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_reg      <= 1'b1;
            prev_rx_reg    <= 1'b1;
            since_reg      <= '0;
            count_reg      <= '0;
            valid_reg      <= 1'b0;
            sl_reg         <= 1'b0;
            idx_reg        <= '0;
            rem_reg        <= '0;
            pass_reg       <= '0;
            gap_reg        <= '0;
            tx_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_reg      <= first_next;
            prev_rx_reg    <= prev_rx_next;
            since_reg      <= since_next;
            count_reg      <= count_next;
            valid_reg      <= valid_next;
            sl_reg         <= sl_next;
            idx_reg        <= idx_next;
            rem_reg        <= rem_next;
            pass_reg       <= pass_next;
            gap_reg        <= gap_next;
            tx_reg         <= tx_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg0_reg      <= seg0_next;
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // checks
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a beat while output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept && out_valid_reg && out_stall |=> skid_valid_reg)
        else $error("beat accepted under output stall was not parked in skid register");

    a_write_only_capturing: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg == ST_CAPT && count_reg < CNT_W'(MAX_TRANSITIONS))
        else $error("duration write outside capture or past store depth");

    a_replay_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PLAY |-> idx_reg <= count_reg && count_reg != '0)
        else $error("replay index beyond stored count");

endmodule

// ===== verif/ook_pulse_capture_replay_top_tb.sv =====
`timescale 1ns / 100ps

module ook_pulse_capture_replay_top_tb
    import ookpcr_pkg::*;
();

    class pulse_status_board;
        // configuration copy
        logic [MAX_PULSE_W-1:0] pulse_limit;
        logic [MIN_TRANS_W-1:0] min_trans;
        logic [TIMEOUT_W-1:0]   idle_limit;
        logic [REPEAT_W-1:0]    passes_cfg;
        logic [GAP_W-1:0]       gap_cfg;

        // capture / replay state
        logic [1:0]          mode;
        bit                  armed_first;
        bit                  last_rx;
        logic [SINCE_W-1:0]  since_edge;
        logic [TC_W-1:0]     stored;
        bit                  rec_valid;
        bit                  first_level;
        logic [19:0]         durations [MAX_TRANSITIONS_DEF];
        logic [TC_W-1:0]     seg_idx;
        logic [DUR_W-1:0]    seg_left;
        logic [REPEAT_W-1:0] pass_no;
        logic [GAP_W-1:0]    gap_left;
        bit                  tx;

        out_item_t   status_due[$];
        int unsigned failures;
        int unsigned checked;

        function new();
            pulse_limit = MAX_PULSE_RST;
            min_trans   = MIN_TRANS_RST;
            idle_limit  = TIMEOUT_RST;
            passes_cfg  = REPEAT_RST;
            gap_cfg     = GAP_RST;
            mode        = MODE_IDLE;
            armed_first = 1'b1;
            last_rx     = 1'b1;
            since_edge  = '0;
            stored      = '0;
            rec_valid   = 1'b0;
            first_level = 1'b0;
            seg_idx     = '0;
            seg_left    = '0;
            pass_no     = '0;
            gap_left    = '0;
            tx          = 1'b0;
            failures    = 0;
            checked     = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_MAX_PULSE: pulse_limit = value[MAX_PULSE_W-1:0];
                REG_MIN_TRANS: min_trans   = value[MIN_TRANS_W-1:0];
                REG_TIMEOUT:   idle_limit  = value[TIMEOUT_W-1:0];
                REG_REPEAT:    passes_cfg  = value[REPEAT_W-1:0];
                REG_GAP:       gap_cfg     = value[GAP_W-1:0];
                default: ;
            endcase
        endfunction

        function void close_capture();
            if (stored >= min_trans)
            begin
                mode      = MODE_DONE;
                rec_valid = 1'b1;
            end
            else
            begin
                mode      = MODE_IDLE;
                rec_valid = 1'b0;
            end
        endfunction

        function logic [DUR_W-1:0] seg_len(logic [TC_W-1:0] i);
            if (durations[i] > REPLAY_CLAMP)
                return REPLAY_CLAMP;
            return durations[i][DUR_W-1:0];
        endfunction

        function void start_pass();
            seg_idx  = '0;
            tx       = !first_level;
            seg_left = seg_len('0);
        endfunction

        function void replay_step();
            while (1)
            begin
                // finished segments toggle the line; the last one opens the gap
                while (seg_idx < stored && seg_left == 0)
                begin
                    seg_idx++;
                    tx = !tx;
                    if (seg_idx < stored)
                        seg_left = seg_len(seg_idx);
                    else
                    begin
                        tx       = 1'b0;
                        gap_left = gap_cfg;
                    end
                end
                if (seg_idx < stored || gap_left != 0)
                    break;
                pass_no++;
                if (pass_no >= passes_cfg)
                begin
                    mode = MODE_DONE;
                    tx   = 1'b0;
                    return;
                end
                start_pass();
            end
            if (seg_idx < stored)
                seg_left--;
            else
            begin
                tx = 1'b0;
                gap_left--;
            end
        endfunction

        function void capture_step(bit rx);
            logic [SINCE_W-1:0] elapsed;
            elapsed = (since_edge == '1) ? since_edge : since_edge + 1'b1;
            if (rx != last_rx)
            begin
                if (stored >= MAX_TRANSITIONS_DEF)
                begin
                    close_capture();
                    return;
                end
                if (armed_first)
                begin
                    armed_first = 1'b0;
                    first_level = rx;
                end
                else if (elapsed <= pulse_limit)
                begin
                    durations[stored] = elapsed[19:0];
                    stored++;
                end
                since_edge = '0;
            end
            else
            begin
                since_edge = elapsed;
                if (!armed_first && elapsed > idle_limit)
                    close_capture();
            end
        endfunction

        function void note_tick(in_item_t item);
            out_item_t due;
            if (item.cmd == CMD_START)
            begin
                stored      = '0;
                rec_valid   = 1'b0;
                first_level = 1'b0;
                mode        = MODE_CAPT;
                armed_first = 1'b1;
                since_edge  = '0;
                tx          = 1'b0;
                seg_idx     = '0;
                seg_left    = '0;
                pass_no     = '0;
                gap_left    = '0;
            end
            else if (mode == MODE_CAPT)
            begin
                if (item.cmd == CMD_STOP)
                    close_capture();
                else
                    capture_step(item.rx_level);
            end
            else if (mode == MODE_PLAY)
                replay_step();
            else if (item.cmd == CMD_PLAY && rec_valid && stored != 0 && passes_cfg != 0)
            begin
                // the command beat is already the first replay microsecond
                mode     = MODE_PLAY;
                pass_no  = '0;
                gap_left = '0;
                start_pass();
                replay_step();
            end
            last_rx = item.rx_level;
            if (mode != MODE_PLAY)
                tx = 1'b0;
            due.tx_level         = tx;
            due.mode             = mode;
            due.transition_count = stored;
            due.signal_valid     = rec_valid;
            due.lead_level       = first_level;
            status_due.push_back(due);
        endfunction

        function void check_status(out_item_t got);
            out_item_t due;
            checked++;
            if (status_due.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("beat %0d: unexpected status beat", checked);
                return;
            end
            due = status_due.pop_front();
            if (got.tx_level !== due.tx_level || got.mode !== due.mode ||
                got.transition_count !== due.transition_count ||
                got.signal_valid !== due.signal_valid || got.lead_level !== due.lead_level)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("beat %0d exp/got: tx %0b/%0b mode %0d/%0d count %0d/%0d",
                             checked, due.tx_level, got.tx_level, due.mode, got.mode,
                             due.transition_count, got.transition_count);
                    $display("    valid %0b/%0b lead %0b/%0b",
                             due.signal_valid, got.signal_valid,
                             due.lead_level, got.lead_level);
                end
            end
        endfunction
    endclass

    localparam int IDLE_PCT        = 24;
    localparam int STALL_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_PHASES   = 5;
    localparam int TICKS_PER_PHASE = 85;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit                quiet;
    int unsigned       phase_ticks;
    int unsigned       idle_run = 0;
    pulse_status_board board;

    ook_pulse_capture_replay_top u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // one beat per call; valid stays up after acceptance unless the next call idles
    task automatic send_tick(input cmd_t cmd, input bit rx);
        in_item_t item;
        item.cmd      = cmd;
        item.rx_level = rx;
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        board.note_tick(item);
        phase_ticks++;
    endtask

    task automatic hold_level(input bit rx, input int n);
        repeat (n) send_tick(CMD_NONE, rx);
    endtask

    // random levels; cmd_pct percent of beats carry a random command
    task automatic noise(input int n, input int cmd_pct);
        repeat (n)
            send_tick(($urandom_range(99) < cmd_pct) ? cmd_t'($urandom_range(3)) : CMD_NONE,
                      $urandom_range(1));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (board.status_due.size() != 0);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, value[CFG_DATA_W-1:0]);
    endtask

    task automatic set_config(input int unsigned pulse_limit, input int unsigned min_trans,
                              input int unsigned idle_limit, input int unsigned passes,
                              input int unsigned gap);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_MAX_PULSE, pulse_limit);
        write_reg(REG_MIN_TRANS, min_trans);
        write_reg(REG_TIMEOUT, idle_limit);
        write_reg(REG_REPEAT, passes);
        write_reg(REG_GAP, gap);
        cfg_valid <= 1'b0;
    endtask

    // arm, feed a short pulse train, end capture one of several ways, then replay
    task automatic capture_and_replay();
        bit lvl;
        int edges;
        lvl = $urandom_range(1);
        send_tick(CMD_START, lvl);
        hold_level(lvl, $urandom_range(0, 2));
        edges = $urandom_range(0, 10);
        repeat (edges)
        begin
            lvl = !lvl;
            hold_level(lvl, $urandom_range(1, 5));
        end
        case ($urandom_range(3))
            0: send_tick(CMD_STOP, lvl);
            1: hold_level(lvl, $urandom_range(0, 14));
            2: noise(3, 40);
            default: ;
        endcase
        send_tick(CMD_PLAY, $urandom_range(1));
        noise($urandom_range(0, 50), ($urandom_range(3) == 0) ? 6 : 0);
    endtask

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            board.check_status(out_data);
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_run <= 0;
        else if (idle_run >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_run <= idle_run + 1;
    end

    initial
    begin
        int phase;
        board     = new();
        quiet     = 1'b0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        set_config(2, 2, 4, 2, 1);
        send_tick(CMD_NONE, 1'b0);      // idle: level change does nothing
        send_tick(CMD_STOP, 1'b1);      // stop outside capture
        send_tick(CMD_PLAY, 1'b1);      // no valid record yet
        send_tick(CMD_START, 1'b0);     // level change on the start beat is no edge
        send_tick(CMD_NONE, 1'b1);      // first edge sets start level
        send_tick(CMD_NONE, 1'b1);
        send_tick(CMD_NONE, 1'b0);      // stores 2
        send_tick(CMD_NONE, 1'b1);      // stores 1
        hold_level(1'b1, 2);
        send_tick(CMD_NONE, 1'b0);      // too long, dropped
        send_tick(CMD_STOP, 1'b0);      // enough stored: captured
        send_tick(CMD_PLAY, 1'b0);
        noise(3, 0);
        send_tick(CMD_STOP, 1'b1);      // ignored while replaying
        send_tick(CMD_PLAY, 1'b0);      // ignored while replaying
        send_tick(CMD_START, 1'b1);     // aborts the replay
        send_tick(CMD_NONE, 1'b0);
        hold_level(1'b1, 6);            // one stored, then timeout with too few
        send_tick(CMD_PLAY, 1'b1);

        // random pulse trains under small random settings
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_config($urandom_range(1, 6), $urandom_range(0, 6), $urandom_range(1, 12),
                       (phase == 0) ? 0 : $urandom_range(1, 3), $urandom_range(0, 8));
            quiet       = (phase == 2);
            phase_ticks = 0;
            while (phase_ticks < TICKS_PER_PHASE)
            begin
                capture_and_replay();
                if ($urandom_range(7) == 0)
                    wait_drained();
            end
        end
        quiet = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.failures == 0 && board.status_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
